[sv/pcs_pkg.sv]
`default_nettype none

package pcs_pkg;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic STATUS_OK           = 1'b0;
    localparam logic STATUS_OUT_OF_RANGE = 1'b1;

    localparam logic [2:0] MAX_ACCESS_BYTES = 3'd4;

    localparam logic [11:0] OFF_VENDOR_ID   = 12'h000;
    localparam logic [11:0] OFF_DEVICE_ID   = 12'h002;
    localparam logic [11:0] OFF_COMMAND     = 12'h004;
    localparam logic [11:0] OFF_REVISION    = 12'h008;
    localparam logic [11:0] OFF_CLASS       = 12'h009;
    localparam logic [11:0] OFF_HEADER_TYPE = 12'h00E;
    localparam logic [11:0] OFF_CAP_PTR     = 12'h034;
    localparam logic [11:0] OFF_PMCSR       = 12'h044;
    localparam logic [11:0] OFF_MSI_CTRL    = 12'h052;
    localparam logic [11:0] OFF_MSIX_CTRL   = 12'h062;

    localparam logic [15:0] COMMAND_MASK    = 16'h0547;
    localparam logic [15:0] PMCSR_MASK      = 16'h8103;
    localparam logic [15:0] MSIX_WR_MASK    = 16'hC000;
    localparam logic [15:0] MSIX_KEEP_MASK  = 16'h07FF;

    localparam logic [1:0] PM_STATE_D0    = 2'd0;
    localparam logic [1:0] PM_STATE_D3HOT = 2'd3;

    function automatic logic [31:0] image_word(input logic [9:0] word_idx);
        logic [31:0] w;
        case (word_idx)
            10'd0:   w = 32'h70011D94;
            10'd1:   w = 32'h00100000;
            10'd2:   w = 32'h01080201;
            10'd4:   w = 32'h00000004;
            10'd11:  w = 32'h00011D94;
            10'd13:  w = 32'h00000040;
            10'd15:  w = 32'h00000100;
            10'd16:  w = 32'h00035001;
            10'd20:  w = 32'h00806005;
            10'd24:  w = 32'h001F7011;
            10'd25:  w = 32'h00002000;
            10'd26:  w = 32'h00003000;
            10'd28:  w = 32'h00020010;
            10'd29:  w = 32'h00008001;
            10'd30:  w = 32'h00000010;
            10'd31:  w = 32'h00000001;
            10'd32:  w = 32'h00110000;
            default: w = 32'h00000000;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/pcs_ram.sv]
`default_nettype none

module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/pcie_config_space_regfile.sv]
// PCIe type-0 configuration space, byte addressed, SPACE_SIZE bytes.
// Input channel (in_valid/in_ready) carries one transaction: func (read or
// write), offset, access_length (1 to 4 bytes, above 4 counts as 4) and
// write_data, little-endian with the lowest byte at offset.
// Output channel (out_valid/out_ready) returns one result per transaction:
// read_data (zero for writes and rejected accesses) and status (1 when
// offset plus length runs past the end of the space).
// The space lives in two 32-bit RAM banks (even and odd words), so any
// unaligned access of up to 4 bytes touches one entry of each bank.
// The banks are read at the accepting edge; in ST_HOLD, once the output
// register is free, the data are modified and written back and the result
// is registered. No new transaction is taken during this read-modify-write
// of the banks; a new one is taken as soon as the previous one has moved
// into the output register.
// Reset: an initialization pass over the SPACE_SIZE/8 (rounded up) entries
// of each bank writes the power-on image; in_ready stays low during it.
// Stall: a result waiting on out_ready holds in the output register; the
// next transaction is accepted and then waits before write-back until the
// output register frees up.
`default_nettype none

module pcie_config_space_regfile
    import pcs_pkg::*;
#(
    parameter int SPACE_SIZE = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [11:0] offset,
    input  wire logic [2:0]  access_length,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic             status
);

    localparam int BANK_DEPTH = (SPACE_SIZE + 7) / 8;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [12:0] SPACE_END = 13'(SPACE_SIZE);
    localparam logic [BANK_AW-1:0] LAST_PAIR = BANK_AW'(BANK_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [BANK_AW-1:0] init_cnt_reg, init_cnt_next;
    logic               func_reg;
    logic [11:0]        off_reg;
    logic [2:0]         len_reg;
    logic [31:0]        wdata_reg;
    logic               oor_reg;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        read_data_reg, read_data_next;
    logic               status_reg, status_next;

    logic        accept;
    logic        finish;
    logic [2:0]  len_sat;
    logic [12:0] end_sum;
    logic        oor_in;

    logic [BANK_AW-1:0] rd_addr0, rd_addr1, wr_addr0, wr_addr1;
    logic [BANK_AW-1:0] req_addr0, req_addr1;
    logic [31:0]        rdata0, rdata1, wdata0, wdata1;
    logic               we;

    logic [31:0] lo_word, hi_word;
    logic [63:0] window, new_window;
    logic [31:0] rd_raw, rd_mask;
    logic [31:0] wr_val;
    logic [2:0]  wr_cnt;
    logic [15:0] v16;
    logic [2:0]  pos;
    logic        do_write;

    assign len_sat  = (access_length > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : access_length;
    assign end_sum  = {1'b0, offset} + {10'd0, len_sat};
    assign oor_in   = (end_sum > SPACE_END);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

    // Bank 0 holds even words, bank 1 odd words.
    assign req_addr0 = BANK_AW'({1'b0, off_reg[11:3]} + {9'd0, off_reg[2]});
    assign req_addr1 = BANK_AW'(off_reg[11:3]);
    assign rd_addr0  = (state_reg == ST_IDLE)
                     ? BANK_AW'({1'b0, offset[11:3]} + {9'd0, offset[2]}) : req_addr0;
    assign rd_addr1  = (state_reg == ST_IDLE) ? BANK_AW'(offset[11:3]) : req_addr1;

    assign lo_word = off_reg[2] ? rdata1 : rdata0;
    assign hi_word = off_reg[2] ? rdata0 : rdata1;
    assign window  = {hi_word, lo_word};

    always_comb
    begin
        case (off_reg[1:0])
            2'd0:    rd_raw = window[31:0];
            2'd1:    rd_raw = window[39:8];
            2'd2:    rd_raw = window[47:16];
            2'd3:    rd_raw = window[55:24];
            default: rd_raw = window[31:0];
        endcase
        case (len_reg)
            3'd0:    rd_mask = 32'h00000000;
            3'd1:    rd_mask = 32'h000000FF;
            3'd2:    rd_mask = 32'h0000FFFF;
            3'd3:    rd_mask = 32'h00FFFFFF;
            default: rd_mask = 32'hFFFFFFFF;
        endcase
    end

    assign v16 = wdata_reg[15:0];

    always_comb
    begin
        wr_val = wdata_reg;
        wr_cnt = len_reg;
        if (off_reg == OFF_COMMAND && len_reg >= 3'd2)
        begin
            wr_val = {16'd0, v16 & COMMAND_MASK};
            wr_cnt = 3'd2;
        end
        else if (off_reg == OFF_PMCSR && len_reg >= 3'd2)
        begin
            wr_val = {16'd0, v16 & PMCSR_MASK};
            wr_cnt = (v16[1:0] == PM_STATE_D0 || v16[1:0] == PM_STATE_D3HOT) ? 3'd2 : 3'd0;
        end
        else if (off_reg == OFF_MSIX_CTRL && len_reg >= 3'd2)
        begin
            wr_val = {16'd0, (v16 & MSIX_WR_MASK) | (rd_raw[15:0] & MSIX_KEEP_MASK)};
            wr_cnt = 3'd2;
        end
        else if (off_reg == OFF_MSI_CTRL && len_reg >= 3'd2)
        begin
            wr_val = {16'd0, v16};
            wr_cnt = 3'd2;
        end
        else if (off_reg == OFF_VENDOR_ID || off_reg == OFF_DEVICE_ID ||
                 off_reg == OFF_REVISION || off_reg == OFF_CLASS ||
                 off_reg == OFF_HEADER_TYPE || off_reg == OFF_CAP_PTR)
        begin
            wr_cnt = 3'd0;
        end
    end

    always_comb
    begin
        new_window = window;
        pos        = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            pos = {1'b0, off_reg[1:0]} + 3'(i);
            if (3'(i) < wr_cnt)
            begin
                new_window[{pos, 3'b000} +: 8] = wr_val[8*i +: 8];
            end
        end
    end

    assign do_write = finish && (func_reg == FUNC_WRITE) && !oor_reg && (wr_cnt != 3'd0);

    assign we       = (state_reg == ST_INIT) || do_write;
    assign wr_addr0 = (state_reg == ST_INIT) ? init_cnt_reg : req_addr0;
    assign wr_addr1 = (state_reg == ST_INIT) ? init_cnt_reg : req_addr1;
    assign wdata0   = (state_reg == ST_INIT) ? image_word(10'({init_cnt_reg, 1'b0}))
                    : (off_reg[2] ? new_window[63:32] : new_window[31:0]);
    assign wdata1   = (state_reg == ST_INIT) ? image_word(10'({init_cnt_reg, 1'b1}))
                    : (off_reg[2] ? new_window[31:0] : new_window[63:32]);

    always_comb
    begin
        state_next     = state_reg;
        init_cnt_next  = init_cnt_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + BANK_AW'(1);
                if (init_cnt_reg == LAST_PAIR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = oor_reg ? STATUS_OUT_OF_RANGE : STATUS_OK;
                    read_data_next = (func_reg == FUNC_READ && !oor_reg)
                                   ? (rd_raw & rd_mask) : 32'd0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
        if (accept)
        begin
            func_reg  <= func;
            off_reg   <= offset;
            len_reg   <= len_sat;
            wdata_reg <= write_data;
            oor_reg   <= oor_in;
        end
    end

    pcs_ram #(
        .WIDTH (32),
        .DEPTH (BANK_DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr0),
        .wdata (wdata0),
        .raddr (rd_addr0),
        .rdata (rdata0)
    );

    pcs_ram #(
        .WIDTH (32),
        .DEPTH (BANK_DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr1),
        .wdata (wdata1),
        .raddr (rd_addr1),
        .rdata (rdata1)
    );

endmodule

`default_nettype wire

[sv/pcs_checker.sv]
`default_nettype none

module pcs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] read_data,
    input wire logic        status
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> read_data == 32'd0)
    else $error("rejected access returned data");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken during read-modify-write");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced without a transaction in flight");

endmodule

bind pcie_config_space_regfile pcs_checker u_pcs_checker (.*);

`default_nettype wire

[dv/tb_pcie_config_space_regfile.sv]
module tb_pcie_config_space_regfile
    import pcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPACE_SIZE     = 256;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] rdata;
        logic        st;
    } cfg_response_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [11:0] offset;
    logic [2:0]  access_length;
    logic [31:0] write_data;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic        status;

    logic [7:0]    cfg_mirror [SPACE_SIZE];
    cfg_response_t pending_responses [$];

    bit idle_on;
    int mismatches;
    int responses_checked;
    int reads_sent;
    int writes_sent;
    int rejects_sent;

    pcie_config_space_regfile #(
        .SPACE_SIZE(SPACE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .offset(offset),
        .access_length(access_length),
        .write_data(write_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic set_mirror_word(input int addr, input logic [31:0] value);
        for (int i = 0; i < 4; i++)
            cfg_mirror[addr + i] = value[8*i +: 8];
    endtask

    task automatic load_power_on_image();
        foreach (cfg_mirror[i])
            cfg_mirror[i] = 8'h00;
        set_mirror_word('h00, 32'h70011D94);
        set_mirror_word('h04, 32'h00100000);
        set_mirror_word('h08, 32'h01080201);
        set_mirror_word('h10, 32'h00000004);
        set_mirror_word('h2C, 32'h00011D94);
        set_mirror_word('h34, 32'h00000040);
        set_mirror_word('h3C, 32'h00000100);
        set_mirror_word('h40, 32'h00035001);
        set_mirror_word('h50, 32'h00806005);
        set_mirror_word('h60, 32'h001F7011);
        set_mirror_word('h64, 32'h00002000);
        set_mirror_word('h68, 32'h00003000);
        set_mirror_word('h70, 32'h00020010);
        set_mirror_word('h74, 32'h00008001);
        set_mirror_word('h78, 32'h00000010);
        set_mirror_word('h7C, 32'h00000001);
        set_mirror_word('h80, 32'h00110000);
    endtask

    function automatic cfg_response_t access_config_mirror(
        input logic        f,
        input logic [11:0] o,
        input logic [2:0]  l,
        input logic [31:0] d
    );
        cfg_response_t r;
        int            n;
        int            base;
        logic [15:0]   v16;
        logic [15:0]   cur16;
        r.rdata = '0;
        r.st    = STATUS_OK;
        n       = (l > MAX_ACCESS_BYTES) ? int'(MAX_ACCESS_BYTES) : int'(l);
        base    = int'(o);
        v16     = d[15:0];
        if (base + n > SPACE_SIZE)
            r.st = STATUS_OUT_OF_RANGE;
        else if (f == FUNC_READ)
        begin
            for (int i = 0; i < n; i++)
                r.rdata[8*i +: 8] = cfg_mirror[base + i];
        end
        else if (o == OFF_COMMAND && n >= 2)
            {cfg_mirror[base + 1], cfg_mirror[base]} = v16 & COMMAND_MASK;
        else if (o == OFF_PMCSR && n >= 2)
        begin
            if (v16[1:0] == PM_STATE_D0 || v16[1:0] == PM_STATE_D3HOT)
                {cfg_mirror[base + 1], cfg_mirror[base]} = v16 & PMCSR_MASK;
        end
        else if (o == OFF_MSIX_CTRL && n >= 2)
        begin
            cur16 = {cfg_mirror[base + 1], cfg_mirror[base]};
            {cfg_mirror[base + 1], cfg_mirror[base]} =
                (v16 & MSIX_WR_MASK) | (cur16 & MSIX_KEEP_MASK);
        end
        else if (o == OFF_MSI_CTRL && n >= 2)
            {cfg_mirror[base + 1], cfg_mirror[base]} = v16;
        else if (o inside {OFF_VENDOR_ID, OFF_DEVICE_ID, OFF_REVISION, OFF_CLASS,
                           OFF_HEADER_TYPE, OFF_CAP_PTR})
        begin
        end
        else
        begin
            for (int i = 0; i < n; i++)
                cfg_mirror[base + i] = d[8*i +: 8];
        end
        return r;
    endfunction

    task automatic send_access(
        input logic        f,
        input logic [11:0] o,
        input logic [2:0]  l,
        input logic [31:0] d
    );
        int            gap;
        cfg_response_t want;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        offset        <= o;
        access_length <= l;
        write_data    <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = access_config_mirror(f, o, l, d);
        pending_responses.push_back(want);
        if (want.st == STATUS_OUT_OF_RANGE)
            rejects_sent++;
        else if (f == FUNC_WRITE)
            writes_sent++;
        else
            reads_sent++;
    endtask

    task automatic test_reset_image();
        send_access(FUNC_READ, OFF_VENDOR_ID, 3'd4, 32'h0);
        send_access(FUNC_READ, OFF_REVISION, 3'd4, 32'hFFFFFFFF);
        send_access(FUNC_READ, 12'h040, 3'd4, 32'h0);
        send_access(FUNC_READ, 12'h061, 3'd3, 32'h0);
        send_access(FUNC_READ, 12'h07F, 3'd2, 32'h0);
    endtask

    task automatic test_read_only_offsets();
        send_access(FUNC_WRITE, OFF_VENDOR_ID, 3'd4, 32'hFFFFFFFF);
        send_access(FUNC_WRITE, OFF_DEVICE_ID, 3'd2, 32'hFFFFFFFF);
        send_access(FUNC_WRITE, OFF_REVISION, 3'd1, 32'hFFFFFFFF);
        send_access(FUNC_WRITE, OFF_CLASS, 3'd3, 32'hFFFFFFFF);
        send_access(FUNC_WRITE, OFF_HEADER_TYPE, 3'd2, 32'hFFFFFFFF);
        send_access(FUNC_WRITE, OFF_CAP_PTR, 3'd1, 32'hFFFFFFFF);
        send_access(FUNC_READ, OFF_VENDOR_ID, 3'd4, 32'h0);
    endtask

    task automatic test_masked_registers();
        send_access(FUNC_WRITE, OFF_COMMAND, 3'd4, 32'hFFFFFFFF);
        send_access(FUNC_READ, OFF_COMMAND, 3'd4, 32'h0);
        send_access(FUNC_WRITE, OFF_COMMAND, 3'd1, 32'h000000FF);
        send_access(FUNC_WRITE, OFF_PMCSR, 3'd2, 32'hFFFFFFF1);
        send_access(FUNC_WRITE, OFF_PMCSR, 3'd2, 32'hFFFFFFFF);
        send_access(FUNC_READ, OFF_PMCSR, 3'd2, 32'h0);
        send_access(FUNC_WRITE, OFF_MSIX_CTRL, 3'd2, 32'h0000FFFF);
        send_access(FUNC_WRITE, OFF_MSI_CTRL, 3'd4, 32'hABCD1234);
        send_access(FUNC_READ, 12'h050, 3'd4, 32'h0);
        send_access(FUNC_READ, 12'h060, 3'd4, 32'h0);
    endtask

    task automatic test_range_and_length();
        send_access(FUNC_READ, 12'hFFF, 3'd1, 32'h0);
        send_access(FUNC_WRITE, 12'(SPACE_SIZE - 3), 3'd4, 32'hFFFFFFFF);
        send_access(FUNC_WRITE, 12'(SPACE_SIZE - 4), 3'd4, 32'hA5C3_0F96);
        send_access(FUNC_READ, 12'(SPACE_SIZE - 4), 3'd4, 32'h0);
        send_access(FUNC_READ, 12'(SPACE_SIZE - 1), 3'd1, 32'h0);
        send_access(FUNC_READ, 12'h010, 3'd0, 32'h0);
        send_access(FUNC_READ, 12'h010, 3'd7, 32'h0);
        send_access(FUNC_READ, 12'(SPACE_SIZE - 3), 3'd5, 32'h0);
    endtask

    task automatic test_random_traffic(input int count);
        logic        f;
        logic [11:0] o;
        logic [2:0]  l;
        logic [31:0] d;
        int          pick;
        for (int k = 0; k < count; k++)
        begin
            if (k % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            f    = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                case ($urandom_range(0, 9))
                    0: o = OFF_VENDOR_ID;
                    1: o = OFF_DEVICE_ID;
                    2: o = OFF_COMMAND;
                    3: o = OFF_REVISION;
                    4: o = OFF_CLASS;
                    5: o = OFF_HEADER_TYPE;
                    6: o = OFF_CAP_PTR;
                    7: o = OFF_PMCSR;
                    8: o = OFF_MSI_CTRL;
                    default: o = OFF_MSIX_CTRL;
                endcase
            end
            else if (pick < 70)
                o = 12'($urandom_range(0, 'h87));
            else if (pick < 90)
                o = 12'($urandom_range(0, SPACE_SIZE - 1));
            else if (pick < 95)
                o = 12'($urandom_range(SPACE_SIZE - 4, SPACE_SIZE - 1));
            else
                o = 12'($urandom_range(0, 4095));
            if ($urandom_range(0, 9) == 0)
                l = 3'($urandom_range(0, 7));
            else
                l = 3'($urandom_range(1, 4));
            d = $urandom();
            send_access(f, o, l, d);
        end
    endtask

    initial
    begin : response_check
        cfg_response_t want;
        int            stall;
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                    report_mismatch($sformatf("unexpected transaction read_data=%h status=%0b",
                                              read_data, status));
                else
                begin
                    want = pending_responses.pop_front();
                    responses_checked++;
                    if (read_data !== want.rdata)
                        report_mismatch($sformatf("read_data %h, want %h",
                                                  read_data, want.rdata));
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0b, want %0b", status, want.st));
                end
                stall = idle_on ? $urandom_range(0, 11) : 0;
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL pcie_config_space_regfile");
        $finish;
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        func          <= FUNC_READ;
        offset        <= '0;
        access_length <= '0;
        write_data    <= '0;
        idle_on       = 1'b1;
        load_power_on_image();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_image();
        test_read_only_offsets();
        test_masked_registers();
        test_range_and_length();
        test_random_traffic(1400);

        // drop valid at the step of the last acceptance
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d reads, %0d writes, %0d out-of-range accesses",
                 reads_sent, writes_sent, rejects_sent);
        $display("checked %0d responses, %0d mismatches", responses_checked, mismatches);
        if (mismatches == 0)
            $display("PASS pcie_config_space_regfile");
        else
            $display("FAIL pcie_config_space_regfile");
        $finish;
    end

endmodule
